[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros shared by the extent scanner
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SVX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SVX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/svx_pkg.sv]
// ---------------------------------------------------------------------------
// svx_pkg
// types, codes and character helpers for the svg extent scanner
// ---------------------------------------------------------------------------
package svx_pkg;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOT   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // characters
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_QM    = 8'h3F;  // '?'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_S     = 8'h73;  // 's'

  localparam int unsigned CLOSE_LEN = 5;    // length of "</svg"

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_LEAD   = 11'b000_0000_0010,
    PH_LT_A   = 11'b000_0000_0100,
    PH_DECL   = 11'b000_0000_1000,
    PH_BODY   = 11'b000_0001_0000,
    PH_POST   = 11'b000_0010_0000,
    PH_LT_B   = 11'b000_0100_0000,
    PH_NAME   = 11'b000_1000_0000,
    PH_TERM   = 11'b001_0000_0000,
    PH_SEARCH = 11'b010_0000_0000,
    PH_CLOSE  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [31:0] region_length;
  } res_word_t;

  function automatic logic [7:0] low_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [7:0] xml_char(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h78;
      3'd1:    r = 8'h6D;
      3'd2:    r = 8'h6C;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] svg_char(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h73;
      3'd1:    r = 8'h76;
      3'd2:    r = 8'h67;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] close_char(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h3C;
      3'd1:    r = 8'h2F;
      3'd2:    r = 8'h73;
      3'd3:    r = 8'h76;
      3'd4:    r = 8'h67;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

[hdl/svx_in_stage.sv]
// ---------------------------------------------------------------------------
// svx_in_stage
// input register: holds one byte word until the scan core takes it
// ---------------------------------------------------------------------------
module svx_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  input  logic              adv,
  output svx_pkg::in_word_t word
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       first_r;
  logic       last_r;
  logic       take;

  assign in_stall  = valid_r && !adv;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take ? 1'b1 : (adv ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r  <= in_data_byte;
      first_r <= in_first_byte;
      last_r  <= in_last_byte;
    end
  end

  assign word.valid      = valid_r;
  assign word.data_byte  = data_r;
  assign word.first_byte = first_r;
  assign word.last_byte  = last_r;

endmodule

[hdl/svx_scan_core.sv]
// ---------------------------------------------------------------------------
// svx_scan_core
// signature check and closing-tag search, one byte per cycle while the result register is free
// ---------------------------------------------------------------------------
module svx_scan_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  svx_pkg::in_word_t  word,
  input  logic               out_free,
  output logic               adv,
  output svx_pkg::res_word_t res
);

  svx_pkg::phase_t        phase_r, phase_nxt, ph_eff;
  logic [2:0]             match_r, match_nxt, p_eff, p_srch;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_base, cnt_inc, hit_len;
  logic [63:0]            len_ext;
  logic [7:0]             c, lc;
  logic                   live, hit;
  logic [1:0]             hit_st;

  always_comb begin
    c        = word.data_byte;
    lc       = svx_pkg::low_case(word.data_byte);
    ph_eff   = word.first_byte ? svx_pkg::PH_LEAD : phase_r;
    p_eff    = word.first_byte ? 3'd0 : match_r;
    cnt_base = word.first_byte ? '0 : cnt_r;
    // count saturates at all ones
    cnt_inc  = (&cnt_base) ? cnt_base : cnt_base + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    live     = (ph_eff != svx_pkg::PH_IDLE);
    phase_nxt = ph_eff;
    match_nxt = p_eff;
    hit       = 1'b0;
    hit_st    = svx_pkg::ST_NOT;
    hit_len   = '0;
    p_srch    = 3'd0;

    case (ph_eff)
      svx_pkg::PH_LEAD, svx_pkg::PH_POST: begin
        if (!svx_pkg::is_ws(c)) begin
          if (c != svx_pkg::CH_LT) begin
            hit = 1'b1;
          end else begin
            phase_nxt = (ph_eff == svx_pkg::PH_LEAD) ? svx_pkg::PH_LT_A : svx_pkg::PH_LT_B;
          end
        end
      end
      svx_pkg::PH_LT_A: begin
        if (c == svx_pkg::CH_QM) begin
          phase_nxt = svx_pkg::PH_DECL;
          match_nxt = 3'd0;
        end else if (lc != svx_pkg::CH_S) begin
          hit = 1'b1;
        end else begin
          phase_nxt = svx_pkg::PH_NAME;
          match_nxt = 3'd1;
        end
      end
      svx_pkg::PH_LT_B: begin
        if (lc != svx_pkg::CH_S) begin
          hit = 1'b1;
        end else begin
          phase_nxt = svx_pkg::PH_NAME;
          match_nxt = 3'd1;
        end
      end
      svx_pkg::PH_DECL: begin
        if (p_eff > 3'd2 || lc != svx_pkg::xml_char(p_eff)) begin
          hit = 1'b1;
        end else if (p_eff == 3'd2) begin
          phase_nxt = svx_pkg::PH_BODY;
          match_nxt = 3'd0;
        end else begin
          match_nxt = p_eff + 3'd1;
        end
      end
      svx_pkg::PH_BODY: begin
        // the match position marks a pending '?'
        if (p_eff != 3'd0 && c == svx_pkg::CH_GT) begin
          phase_nxt = svx_pkg::PH_POST;
          match_nxt = 3'd0;
        end else begin
          match_nxt = (c == svx_pkg::CH_QM) ? 3'd1 : 3'd0;
        end
      end
      svx_pkg::PH_NAME: begin
        if (p_eff > 3'd2 || lc != svx_pkg::svg_char(p_eff)) begin
          hit = 1'b1;
        end else if (p_eff == 3'd2) begin
          phase_nxt = svx_pkg::PH_TERM;
          match_nxt = 3'd0;
        end else begin
          match_nxt = p_eff + 3'd1;
        end
      end
      svx_pkg::PH_TERM: begin
        if (!(svx_pkg::is_ws(c) || c == svx_pkg::CH_GT || c == svx_pkg::CH_SLASH)) begin
          hit = 1'b1;
        end else begin
          phase_nxt = svx_pkg::PH_SEARCH;
          match_nxt = 3'd0;
        end
      end
      svx_pkg::PH_SEARCH: begin
        if (p_eff < 3'(svx_pkg::CLOSE_LEN) && lc == svx_pkg::close_char(p_eff)) begin
          p_srch = p_eff + 3'd1;
        end else begin
          p_srch = (lc == svx_pkg::CH_LT) ? 3'd1 : 3'd0;
        end
        if (p_srch >= 3'(svx_pkg::CLOSE_LEN)) begin
          phase_nxt = svx_pkg::PH_CLOSE;
          match_nxt = 3'd0;
        end else begin
          match_nxt = p_srch;
        end
      end
      svx_pkg::PH_CLOSE: begin
        if (c == svx_pkg::CH_GT) begin
          hit     = 1'b1;
          hit_st  = svx_pkg::ST_OK;
          hit_len = cnt_inc;
        end
      end
      default: begin
        phase_nxt = svx_pkg::PH_IDLE;
      end
    endcase

    // end of blob with the region still open
    if (live && !hit && word.last_byte) begin
      hit = 1'b1;
      if (phase_nxt == svx_pkg::PH_SEARCH || phase_nxt == svx_pkg::PH_CLOSE) begin
        hit_st  = svx_pkg::ST_TRUNC;
        hit_len = cnt_inc;
      end
    end

    if (hit) begin
      phase_nxt = svx_pkg::PH_IDLE;
      match_nxt = 3'd0;
    end
  end

  assign len_ext           = 64'(hit_len);
  assign res.valid         = word.valid && live && hit;
  assign res.status        = hit_st;
  assign res.region_length = len_ext[31:0];
  assign adv               = word.valid && (!(live && hit) || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= svx_pkg::PH_IDLE;
      match_r <= 3'd0;
      cnt_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      if (live) begin
        cnt_r <= cnt_inc;
      end
    end
  end

endmodule

[hdl/svx_out_stage.sv]
// ---------------------------------------------------------------------------
// svx_out_stage
// result register: holds a status word until the sink takes it
// ---------------------------------------------------------------------------
module svx_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  svx_pkg::res_word_t res,
  input  logic               adv,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_region_length
);

  logic        valid_r, valid_nxt;
  logic [1:0]  status_r;
  logic [31:0] len_r;
  logic        load;

  assign out_free  = !valid_r || !out_stall;
  assign load      = adv && res.valid;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= res.status;
      len_r    <= res.region_length;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_region_length = len_r;

endmodule

[hdl/svg_extent_scanner_top.sv]
// ---------------------------------------------------------------------------
// svg_extent_scanner_top
// finds the extent of an svg document in a byte stream
// ---------------------------------------------------------------------------
// One byte word a cycle, while in_stall is low, enters an input register; the scan core checks the
// signature (leading whitespace, optional xml declaration, "<svg") and then searches for "</svg" and
// '>', all combinationally from that register, and a region's single status word lands in the result
// register. Throughput is one byte per cycle while the result register is free, set by the
// registered state update of the scan core; a status word follows its byte through the input
// register and then the result register. A region gives complete, not svg or truncated; the
// length counts through the closing '>' and saturates at 2^LENGTH_BITS-1, low 32 bits shown.
module svg_extent_scanner_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_region_length
);

`include "assert_macros.svh"

  svx_pkg::in_word_t  word;
  svx_pkg::res_word_t res;
  logic               adv;
  logic               out_free;

  svx_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .adv           (adv),
    .word          (word)
  );

  svx_scan_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .word     (word),
    .out_free (out_free),
    .adv      (adv),
    .res      (res)
  );

  svx_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (res),
    .adv               (adv),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_region_length (out_region_length)
  );

  // stall only while a word sits in the input register
  `SVX_ASSERT_NOW(a_stall_held, clk, rst_n, in_stall, word.valid, "stall with empty input register")
  // a not-svg status carries no length
  `SVX_ASSERT_NOW(a_not_len, clk, rst_n, out_valid && out_status == svx_pkg::ST_NOT, out_region_length == 32'd0, "not-svg status with nonzero length")
  // a status word from the core is only taken into a free result register
  `SVX_ASSERT_NOW(a_no_overrun, clk, rst_n, adv && res.valid, out_free, "result register overrun")
  // a word that ends a region leaves the core idle
  `SVX_ASSERT_NEXT(a_idle_after, clk, rst_n, adv && res.valid, u_core.phase_r == svx_pkg::PH_IDLE, "core not idle after result")

endmodule
